// ----- rtl/gbs_pkg.sv -----
// Types, codes and constant tables for the GIF block structure scanner.
// No dependencies; every rtl/ file but gbs_if.sv imports this package.
package gbs_pkg;

    localparam int SKIP_W = 10;   // largest skip is a 256-entry color table
    localparam int IDX_W  = 5;    // byte position inside header or app block

    typedef enum logic [3:0] {
        PH_HDR   = 4'd0,
        PH_LSD   = 4'd1,
        PH_GCT   = 4'd2,
        PH_SCAN  = 4'd3,
        PH_LABEL = 4'd4,
        PH_BSIZE = 4'd5,
        PH_BDATA = 4'd6,
        PH_DESC  = 4'd7,
        PH_LCT   = 4'd8,
        PH_CODE  = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_SIG    = 3'd1,
        ST_BAD_VER    = 3'd2,
        ST_BAD_ASPECT = 3'd3,
        ST_BAD_CODE   = 3'd4,
        ST_TRUNC      = 3'd5
    } status_t;

    // Result flag bit positions
    localparam int RF_V89  = 0;
    localparam int RF_LOOP = 1;
    localparam int RF_GC   = 2;

    localparam logic [7:0] CH_8       = 8'h38;
    localparam logic [7:0] CH_7       = 8'h37;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_TERM    = 8'h3B;   // ';'
    localparam logic [7:0] CH_EXT     = 8'h21;   // '!'
    localparam logic [7:0] CH_IMG     = 8'h2C;   // ','
    localparam logic [7:0] LBL_APP    = 8'hFF;
    localparam logic [7:0] LBL_GC     = 8'hF9;
    localparam logic [7:0] ASPECT_ALT = 8'd49;
    localparam logic [7:0] CODE_MIN   = 8'd2;
    localparam logic [7:0] CODE_LIM   = 8'd12;
    localparam logic [7:0] FLAG_TABLE = 8'h80;

    localparam logic [IDX_W-1:0] HDR_LAST   = IDX_W'(5);
    localparam logic [IDX_W-1:0] LSD_FLAGS  = IDX_W'(10);
    localparam logic [IDX_W-1:0] LSD_ASPECT = IDX_W'(12);
    localparam logic [IDX_W-1:0] DESC_FLAGS = IDX_W'(9);
    localparam logic [IDX_W-1:0] APP_IDLEN  = IDX_W'(14);
    localparam logic [IDX_W-1:0] APP_LOOPLO = IDX_W'(15);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [15:0] image_count;
        status_t     status;
        logic [15:0] loop_count;
        logic        version_89a;
        logic        loop_ext_found;
        logic        graphic_control_first;
    } result_t;

    function automatic logic [7:0] sig_byte(input logic [1:0] i);
        case (i)
            2'd0:    sig_byte = 8'h47;
            2'd1:    sig_byte = 8'h49;
            2'd2:    sig_byte = 8'h46;
            default: sig_byte = 8'h00;
        endcase
    endfunction

    // Expected bytes of the looping application extension's first sub-blocks
    function automatic logic [7:0] app_ident_byte(input logic [3:0] i);
        case (i)
            4'd0:    app_ident_byte = 8'd11;
            4'd1:    app_ident_byte = 8'h4E;
            4'd2:    app_ident_byte = 8'h45;
            4'd3:    app_ident_byte = 8'h54;
            4'd4:    app_ident_byte = 8'h53;
            4'd5:    app_ident_byte = 8'h43;
            4'd6:    app_ident_byte = 8'h41;
            4'd7:    app_ident_byte = 8'h50;
            4'd8:    app_ident_byte = 8'h45;
            4'd9:    app_ident_byte = 8'h32;
            4'd10:   app_ident_byte = 8'h2E;
            4'd11:   app_ident_byte = 8'h30;
            4'd12:   app_ident_byte = 8'd3;
            4'd13:   app_ident_byte = 8'd1;
            default: app_ident_byte = 8'h00;
        endcase
    endfunction

    // Color table size in bytes: 3 * 2^(n+1)
    function automatic logic [SKIP_W-1:0] table_bytes(input logic [7:0] flags);
        table_bytes = SKIP_W'(6) << flags[2:0];
    endfunction

endpackage

// ----- rtl/gbs_if.sv -----
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on nothing; widths follow the fixed field widths.
interface gbs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gbs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] image_count;
    logic [2:0]  status;
    logic [15:0] loop_count;
    logic        version_89a;
    logic        loop_ext_found;
    logic        graphic_control_first;

    modport source (output valid, output image_count, output status, output loop_count,
                    output version_89a, output loop_ext_found,
                    output graphic_control_first, input ready);
    modport sink   (input valid, input image_count, input status, input loop_count,
                    input version_89a, input loop_ext_found,
                    input graphic_control_first, output ready);
endinterface

// ----- rtl/gbs_in_reg.sv -----
// Input register stage: holds one accepted byte until the parser takes it.
// Depends on gbs_pkg and gbs_in_if.
module gbs_in_reg
    import gbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    gbs_in_if.sink     in_ch,
    input  logic       advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    item_t item_reg;

    assign in_ch.ready = !valid_reg || advance;
    assign item_valid  = valid_reg;
    assign item        = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            valid_reg <= in_ch.valid;
        end
    end

    // Payload: load on every transaction
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.data_byte <= in_ch.data_byte;
            item_reg.last_byte <= in_ch.last_byte;
        end
    end

endmodule

// ----- rtl/gbs_parse.sv -----
// Parser state and per-byte next-state logic for the GIF block structure.
// Depends on gbs_pkg.
module gbs_parse
    import gbs_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    output logic    res_valid,
    output result_t res
);

    phase_t                 phase_reg, phase_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [SKIP_W-1:0]      skip_reg, skip_next;
    logic [7:0]             pfb_reg, pfb_next;
    logic [COUNT_WIDTH-1:0] img_reg, img_next;
    logic [15:0]            loop_reg, loop_next;
    logic                   app_reg, app_next;
    logic                   ext_reg, ext_next;
    logic [2:0]             rf_reg, rf_next;
    logic                   fin_reg, fin_next;

    logic                   emit;
    status_t                st;
    logic                   track;
    logic [IDX_W-1:0]       app_idx;
    logic [SKIP_W-1:0]      skip_dec;
    logic [IDX_W-1:0]       desc_idx;
    logic [7:0]             b;

    assign b = item.data_byte;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        skip_next  = skip_reg;
        pfb_next   = pfb_reg;
        img_next   = img_reg;
        loop_next  = loop_reg;
        app_next   = app_reg;
        ext_next   = ext_reg;
        rf_next    = rf_reg;
        fin_next   = fin_reg;
        emit       = 1'b0;
        st         = ST_OK;
        track      = 1'b0;
        app_idx    = idx_reg + 1'b1;
        skip_dec   = skip_reg - SKIP_W'(skip_reg != '0);
        desc_idx   = idx_reg + 1'b1;

        if (!fin_reg)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    if (idx_reg < IDX_W'(3))
                    begin
                        if (b != sig_byte(idx_reg[1:0]))
                            app_next = 1'b0;
                    end
                    else if (idx_reg == IDX_W'(3))
                    begin
                        if (b != CH_8)
                            pfb_next[0] = 1'b1;
                    end
                    else if (idx_reg == IDX_W'(4))
                    begin
                        if (b == CH_9)
                            pfb_next[1] = 1'b1;
                        else if (b != CH_7)
                            pfb_next[0] = 1'b1;
                    end
                    else if (b != CH_A)
                    begin
                        pfb_next[0] = 1'b1;
                    end
                    if (idx_reg >= HDR_LAST)
                    begin
                        if (!app_next)
                        begin
                            emit = 1'b1;
                            st   = ST_BAD_SIG;
                        end
                        else if (pfb_next[0])
                        begin
                            emit = 1'b1;
                            st   = ST_BAD_VER;
                        end
                        else
                        begin
                            if (pfb_next[1])
                                rf_next[RF_V89] = 1'b1;
                            phase_next = PH_LSD;
                        end
                        app_next = 1'b0;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                PH_LSD:
                begin
                    if (idx_reg == LSD_FLAGS)
                        pfb_next = b;
                    if (idx_reg >= LSD_ASPECT)
                    begin
                        if (b != 8'd0 && b != ASPECT_ALT)
                        begin
                            emit = 1'b1;
                            st   = ST_BAD_ASPECT;
                        end
                        else if ((pfb_reg & FLAG_TABLE) != 8'd0)
                        begin
                            skip_next  = table_bytes(pfb_reg);
                            phase_next = PH_GCT;
                        end
                        else
                        begin
                            phase_next = PH_SCAN;
                        end
                    end
                    idx_next = idx_reg + 1'b1;
                end
                PH_GCT, PH_LCT:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                        phase_next = (phase_reg == PH_GCT) ? PH_SCAN : PH_CODE;
                end
                PH_LABEL:
                begin
                    app_next = 1'b0;
                    if (!ext_reg)
                    begin
                        ext_next = 1'b1;
                        if (rf_reg[RF_V89] && b == LBL_APP)
                        begin
                            app_next = 1'b1;
                            idx_next = '0;
                        end
                        else if (b == LBL_GC)
                        begin
                            rf_next[RF_GC] = 1'b1;
                        end
                    end
                    phase_next = PH_BSIZE;
                end
                PH_BSIZE:
                begin
                    track = 1'b1;
                    if (b == 8'd0)
                    begin
                        phase_next = PH_SCAN;
                    end
                    else
                    begin
                        skip_next  = {{(SKIP_W-8){1'b0}}, b};
                        phase_next = PH_BDATA;
                    end
                end
                PH_BDATA:
                begin
                    track     = 1'b1;
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                        phase_next = PH_BSIZE;
                end
                PH_DESC:
                begin
                    idx_next = desc_idx;
                    if (desc_idx >= DESC_FLAGS)
                    begin
                        if (b[7])
                        begin
                            skip_next  = table_bytes(b);
                            phase_next = PH_LCT;
                        end
                        else
                        begin
                            phase_next = PH_CODE;
                        end
                    end
                end
                PH_CODE:
                begin
                    if (b < CODE_MIN || b >= CODE_LIM)
                    begin
                        emit = 1'b1;
                        st   = ST_BAD_CODE;
                    end
                    else
                    begin
                        if (img_reg != '1)
                            img_next = img_reg + 1'b1;
                        app_next   = 1'b0;
                        phase_next = PH_BSIZE;
                    end
                end
                default:
                begin
                    // Scan between blocks; stray bytes are skipped
                    phase_next = PH_SCAN;
                    if (b == CH_TERM)
                    begin
                        emit = 1'b1;
                        st   = ST_OK;
                    end
                    else if (b == CH_EXT)
                    begin
                        phase_next = PH_LABEL;
                    end
                    else if (b == CH_IMG)
                    begin
                        idx_next   = '0;
                        phase_next = PH_DESC;
                    end
                end
            endcase

            // Follow the application extension sub-blocks while the check is live
            if (track && app_reg)
            begin
                idx_next = app_idx;
                if (app_idx <= APP_IDLEN)
                begin
                    if (b != app_ident_byte(4'(app_idx - 1'b1)))
                        app_next = 1'b0;
                    else if (app_idx == APP_IDLEN)
                        rf_next[RF_LOOP] = 1'b1;
                end
                else if (app_idx == APP_LOOPLO)
                begin
                    loop_next = {8'd0, b};
                end
                else
                begin
                    loop_next = loop_reg | {b, 8'd0};
                    app_next  = 1'b0;
                end
            end

            if (!emit && item.last_byte)
            begin
                emit = 1'b1;
                st   = ST_TRUNC;
            end
        end

        res.image_count           = 16'(img_next);
        res.status                = st;
        res.loop_count            = loop_next;
        res.version_89a           = rf_next[RF_V89];
        res.loop_ext_found        = rf_next[RF_LOOP];
        res.graphic_control_first = rf_next[RF_GC];
        res_valid                 = advance && emit;

        // Last-marked byte starts the next file; otherwise hold after a result
        if (item.last_byte)
        begin
            phase_next = PH_HDR;
            idx_next   = '0;
            skip_next  = '0;
            pfb_next   = '0;
            img_next   = '0;
            loop_next  = '0;
            app_next   = 1'b1;
            ext_next   = 1'b0;
            rf_next    = '0;
            fin_next   = 1'b0;
        end
        else if (emit)
        begin
            fin_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            idx_reg   <= '0;
            skip_reg  <= '0;
            pfb_reg   <= '0;
            img_reg   <= '0;
            loop_reg  <= '0;
            app_reg   <= 1'b1;
            ext_reg   <= 1'b0;
            rf_reg    <= '0;
            fin_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            skip_reg  <= skip_next;
            pfb_reg   <= pfb_next;
            img_reg   <= img_next;
            loop_reg  <= loop_next;
            app_reg   <= app_next;
            ext_reg   <= ext_next;
            rf_reg    <= rf_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

// ----- rtl/gbs_out_reg.sv -----
// Result register: holds one result until the downstream side takes it.
// Depends on gbs_pkg and gbs_out_if.
module gbs_out_reg
    import gbs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    gbs_out_if.source out_ch,
    input  logic     advance,
    input  logic     res_valid,
    input  result_t  res,
    output logic     slot_free
);

    logic    valid_reg;
    result_t res_reg;

    assign slot_free = !valid_reg || out_ch.ready;

    assign out_ch.valid                 = valid_reg;
    assign out_ch.image_count           = res_reg.image_count;
    assign out_ch.status                = res_reg.status;
    assign out_ch.loop_count            = res_reg.loop_count;
    assign out_ch.version_89a           = res_reg.version_89a;
    assign out_ch.loop_ext_found        = res_reg.loop_ext_found;
    assign out_ch.graphic_control_first = res_reg.graphic_control_first;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res_valid;
        end
        else if (out_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// ----- rtl/gif_block_structure_scanner_top.sv -----
// GIF block structure scanner: one file byte per transaction in, one result per file out.
// A byte is held in the input register, parsed combinationally and its result registered.
// Throughput: one byte per cycle while the result slot is free, set by the single parse
// step between the two registers; a stalled output holds the input after one byte.
// Reset: rst_n clears the parser to the header phase and empties both registers at once.
// Depends on gbs_pkg, gbs_if, gbs_in_reg, gbs_parse and gbs_out_reg.
module gif_block_structure_scanner_top
    import gbs_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    gbs_in_if.sink    in_ch,
    gbs_out_if.source out_ch
);

    logic    item_valid;
    item_t   item;
    logic    slot_free;
    logic    advance;
    logic    res_valid;
    result_t res;

    // Advance the parser whenever a byte is waiting and the result register can take
    // whatever it produces; a byte that makes no result still needs the slot free so
    // results leave in order.
    assign advance = item_valid && slot_free;

    // Input register: decouples the upstream handshake from the parse step.
    gbs_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Parser: walks header, screen descriptor, tables, extensions and image data,
    // and drops bytes after a result until the last-marked byte.
    gbs_parse #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: holds a finished result while the next byte is accepted.
    gbs_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .out_ch    (out_ch),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free)
    );

    // Input backpressure only comes from a full input register behind a stalled output.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (item_valid && out_ch.valid && !out_ch.ready))
        else $error("input stalled without output backpressure");

    // A result produced by the parser appears on the output in the next cycle.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> out_ch.valid)
        else $error("parsed result not presented");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.status <= ST_TRUNC))
        else $error("undefined status code on output");

endmodule

// ----- verif/gif_block_structure_scanner_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for gif_block_structure_scanner_top: byte streams in, one report per file out.
// Depends on gbs_pkg, the gbs_in_if / gbs_out_if channels and the scanner RTL.
module gif_block_structure_scanner_top_tb;
    import gbs_pkg::*;

    localparam int COUNT_WIDTH    = 16;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 70;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int TIMEOUT_CYCLES = 500_000;

    // Percent of cycles the sender idles / the receiver stalls, per traffic phase:
    // free flow, sparse sender, slow receiver, both.
    localparam int TX_IDLE_PCT  [4] = '{0, 84, 0, 29};
    localparam int RX_STALL_PCT [4] = '{0, 0, 84, 29};

    localparam logic [7:0] GIF_SIG [3] = '{8'h47, 8'h49, 8'h46};
    // Sub-block bytes that open the looping application extension
    localparam logic [7:0] LOOP_APP_ID [14] = '{
        8'd11, 8'h4E, 8'h45, 8'h54, 8'h53, 8'h43, 8'h41,
        8'h50, 8'h45, 8'h32, 8'h2E, 8'h30, 8'd3, 8'd1
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       has_want;
        result_t    want;
    } stim_row_t;

    localparam result_t NO_WANT  = '0;
    localparam result_t W_SIG    = '{16'd0, ST_BAD_SIG, 16'd0, 1'b0, 1'b0, 1'b0};
    localparam result_t W_VER    = '{16'd0, ST_BAD_VER, 16'd0, 1'b0, 1'b0, 1'b0};
    localparam result_t W_TRUNC  = '{16'd0, ST_TRUNC, 16'd0, 1'b0, 1'b0, 1'b0};
    localparam result_t W_ASPECT = '{16'd0, ST_BAD_ASPECT, 16'd0, 1'b1, 1'b0, 1'b0};

    localparam int DIRECTED_ROWS = 28;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Signature broken in its third byte: report on the sixth byte,
        // then two bytes that must be dropped silently up to the last mark.
        '{8'h47, 1'b0, 1'b0, NO_WANT},
        '{8'h49, 1'b0, 1'b0, NO_WANT},
        '{8'h58, 1'b0, 1'b0, NO_WANT},
        '{CH_8,  1'b0, 1'b0, NO_WANT},
        '{CH_9,  1'b0, 1'b0, NO_WANT},
        '{CH_A,  1'b0, 1'b1, W_SIG},
        '{8'h00, 1'b0, 1'b0, NO_WANT},
        '{8'hFF, 1'b1, 1'b0, NO_WANT},
        // Version "88a", error report lands on the last-marked byte itself
        '{8'h47, 1'b0, 1'b0, NO_WANT},
        '{8'h49, 1'b0, 1'b0, NO_WANT},
        '{8'h46, 1'b0, 1'b0, NO_WANT},
        '{CH_8,  1'b0, 1'b0, NO_WANT},
        '{CH_8,  1'b0, 1'b0, NO_WANT},
        '{CH_A,  1'b1, 1'b1, W_VER},
        // One-byte file: truncated inside the header
        '{8'hFF, 1'b1, 1'b1, W_TRUNC},
        // Valid 89a header, aspect byte of 50 is rejected
        '{8'h47, 1'b0, 1'b0, NO_WANT},
        '{8'h49, 1'b0, 1'b0, NO_WANT},
        '{8'h46, 1'b0, 1'b0, NO_WANT},
        '{CH_8,  1'b0, 1'b0, NO_WANT},
        '{CH_9,  1'b0, 1'b0, NO_WANT},
        '{CH_A,  1'b0, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, 1'b0, NO_WANT},
        '{8'h00, 1'b0, 1'b0, NO_WANT},
        '{8'h00, 1'b0, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, 1'b0, NO_WANT},
        '{8'h00, 1'b0, 1'b0, NO_WANT},
        '{8'd50, 1'b1, 1'b1, W_ASPECT}
    };

    logic clk = 1'b0;
    logic rst_n;

    gbs_in_if  in_ch ();
    gbs_out_if out_ch ();

    gif_block_structure_scanner_top #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Traffic knobs, written by the stimulus process only
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    bit long_hold_req = 1'b0;

    int items_sent     = 0;
    int mismatch_count = 0;
    bit wide_table_due = 1'b1;

    result_t    awaited_reports [$];
    logic [7:0] file_bytes [$];

    // ------------------------------------------------------------------
    // Scanner state as the predictor sees it
    // ------------------------------------------------------------------
    phase_t                 walk_phase;
    logic [9:0]             walk_index;
    logic [9:0]             skip_left;
    logic [7:0]             flag_byte;    // header: bit0 version bad, bit1 digit '9'
    logic [COUNT_WIDTH-1:0] image_total;
    logic [15:0]            loop_word;
    logic                   app_live;     // signature ok, later app-id match in progress
    logic                   ext_seen;
    logic [2:0]             found_flags;
    logic                   file_done;

    function automatic void clear_scanner();
        walk_phase  = PH_HDR;
        walk_index  = '0;
        skip_left   = '0;
        flag_byte   = '0;
        image_total = '0;
        loop_word   = '0;
        app_live    = 1'b1;
        ext_seen    = 1'b0;
        found_flags = '0;
        file_done   = 1'b0;
    endfunction

    function automatic result_t snapshot(input status_t code);
        result_t r;
        r.image_count           = 16'(image_total);
        r.status                = code;
        r.loop_count            = loop_word;
        r.version_89a           = found_flags[RF_V89];
        r.loop_ext_found        = found_flags[RF_LOOP];
        r.graphic_control_first = found_flags[RF_GC];
        return r;
    endfunction

    // Follow the first application extension: identifier, then the loop count.
    function automatic void track_loop_app(input logic [7:0] b);
        if (!app_live)
            return;
        walk_index++;
        if (walk_index <= 14)
        begin
            if (b != LOOP_APP_ID[walk_index - 1])
                app_live = 1'b0;
            else if (walk_index == 14)
                found_flags[RF_LOOP] = 1'b1;
        end
        else if (walk_index == 15)
        begin
            loop_word = {8'h00, b};
        end
        else
        begin
            loop_word = loop_word | {b, 8'h00};
            app_live  = 1'b0;
        end
    endfunction

    function automatic logic [9:0] color_table_len(input logic [7:0] flags);
        return 10'(3 * (2 << flags[2:0]));
    endfunction

    // Advance the predicted scanner by one byte; got is set when a report is due.
    task automatic parse_gif_byte(input logic [7:0] b, input logic l,
                                  output bit got, output result_t r);
        got = 1'b0;
        r   = '0;
        if (file_done)
        begin
            if (l)
                clear_scanner();
            return;
        end
        case (walk_phase)
            PH_HDR:
            begin
                if (walk_index < 3)
                begin
                    if (b != GIF_SIG[walk_index])
                        app_live = 1'b0;
                end
                else if (walk_index == 3)
                begin
                    if (b != CH_8)
                        flag_byte[0] = 1'b1;
                end
                else if (walk_index == 4)
                begin
                    if (b == CH_9)
                        flag_byte[1] = 1'b1;
                    else if (b != CH_7)
                        flag_byte[0] = 1'b1;
                end
                else if (b != CH_A)
                begin
                    flag_byte[0] = 1'b1;
                end
                if (walk_index >= 5)
                begin
                    if (!app_live)
                    begin
                        r   = snapshot(ST_BAD_SIG);
                        got = 1'b1;
                    end
                    else if (flag_byte[0])
                    begin
                        r   = snapshot(ST_BAD_VER);
                        got = 1'b1;
                    end
                    else
                    begin
                        if (flag_byte[1])
                            found_flags[RF_V89] = 1'b1;
                        walk_phase = PH_LSD;
                    end
                    app_live = 1'b0;
                end
                walk_index++;
            end
            PH_LSD:
            begin
                if (walk_index == 10)
                    flag_byte = b;
                if (walk_index >= 12)
                begin
                    if (b != 8'h00 && b != ASPECT_ALT)
                    begin
                        r   = snapshot(ST_BAD_ASPECT);
                        got = 1'b1;
                    end
                    else if (flag_byte[7])
                    begin
                        skip_left  = color_table_len(flag_byte);
                        walk_phase = PH_GCT;
                    end
                    else
                    begin
                        walk_phase = PH_SCAN;
                    end
                end
                walk_index++;
            end
            PH_GCT, PH_LCT:
            begin
                if (skip_left > 0)
                    skip_left--;
                if (skip_left == 0)
                    walk_phase = (walk_phase == PH_GCT) ? PH_SCAN : PH_CODE;
            end
            PH_LABEL:
            begin
                app_live = 1'b0;
                if (!ext_seen)
                begin
                    ext_seen = 1'b1;
                    if (found_flags[RF_V89] && b == LBL_APP)
                    begin
                        app_live   = 1'b1;
                        walk_index = '0;
                    end
                    else if (b == LBL_GC)
                    begin
                        found_flags[RF_GC] = 1'b1;
                    end
                end
                walk_phase = PH_BSIZE;
            end
            PH_BSIZE:
            begin
                track_loop_app(b);
                if (b == 8'h00)
                begin
                    walk_phase = PH_SCAN;
                end
                else
                begin
                    skip_left  = 10'(b);
                    walk_phase = PH_BDATA;
                end
            end
            PH_BDATA:
            begin
                track_loop_app(b);
                if (skip_left > 0)
                    skip_left--;
                if (skip_left == 0)
                    walk_phase = PH_BSIZE;
            end
            PH_DESC:
            begin
                walk_index++;
                if (walk_index >= 9)
                begin
                    if (b[7])
                    begin
                        skip_left  = color_table_len(b);
                        walk_phase = PH_LCT;
                    end
                    else
                    begin
                        walk_phase = PH_CODE;
                    end
                end
            end
            PH_CODE:
            begin
                if (b < CODE_MIN || b >= CODE_LIM)
                begin
                    r   = snapshot(ST_BAD_CODE);
                    got = 1'b1;
                end
                else
                begin
                    if (image_total != '1)
                        image_total++;
                    app_live   = 1'b0;
                    walk_phase = PH_BSIZE;
                end
            end
            default:
            begin
                walk_phase = PH_SCAN;
                if (b == CH_TERM)
                begin
                    r   = snapshot(ST_OK);
                    got = 1'b1;
                end
                else if (b == CH_EXT)
                begin
                    walk_phase = PH_LABEL;
                end
                else if (b == CH_IMG)
                begin
                    walk_index = '0;
                    walk_phase = PH_DESC;
                end
            end
        endcase
        // A file that ends without its own report is reported as truncated
        if (!got && l)
        begin
            r   = snapshot(ST_TRUNC);
            got = 1'b1;
        end
        if (l)
            clear_scanner();
        else if (got)
            file_done = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // File generator: mostly well-formed files with random content
    // ------------------------------------------------------------------
    function automatic logic [2:0] pick_table_size();
        if ($urandom_range(0, 15) == 0)
            return 3'($urandom_range(2, 6));
        return 3'($urandom_range(0, 1));
    endfunction

    task automatic add_table(input logic [7:0] flags);
        if (flags[7])
            repeat (color_table_len(flags)) file_bytes.push_back(8'($urandom));
    endtask

    task automatic add_sub_blocks();
        int len;
        repeat ($urandom_range(0, 3))
        begin
            len = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(1, 12);
            file_bytes.push_back(8'(len));
            repeat (len) file_bytes.push_back(8'($urandom));
        end
        file_bytes.push_back(8'h00);
    endtask

    task automatic add_extension();
        int pick;
        int spoil;
        file_bytes.push_back(CH_EXT);
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            // Looping application block, now and then with one byte spoiled
            file_bytes.push_back(LBL_APP);
            spoil = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 13) : -1;
            for (int i = 0; i < 14; i++)
                file_bytes.push_back((i == spoil) ? 8'($urandom) : LOOP_APP_ID[i]);
            file_bytes.push_back(8'($urandom));
            file_bytes.push_back(8'($urandom));
            add_sub_blocks();
        end
        else if (pick < 6)
        begin
            file_bytes.push_back(LBL_GC);
            file_bytes.push_back(8'd4);
            repeat (4) file_bytes.push_back(8'($urandom));
            file_bytes.push_back(8'h00);
        end
        else
        begin
            file_bytes.push_back(8'($urandom));
            add_sub_blocks();
        end
    endtask

    task automatic add_image();
        logic [7:0] flags;
        int         code;
        file_bytes.push_back(CH_IMG);
        repeat (8) file_bytes.push_back(8'($urandom));
        flags      = 8'($urandom);
        flags[7]   = ($urandom_range(0, 2) == 0);
        flags[2:0] = pick_table_size();
        file_bytes.push_back(flags);
        add_table(flags);
        if ($urandom_range(0, 11) == 0)
            code = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(12, 255);
        else
            code = $urandom_range(2, 11);
        file_bytes.push_back(8'(code));
        add_sub_blocks();
    endtask

    task automatic build_file();
        logic [7:0] flags;
        int         roll;
        int         keep;
        bit         cut_short;
        file_bytes.delete();
        cut_short = 1'b0;
        // Pure noise now and then
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 16)) file_bytes.push_back(8'($urandom));
            return;
        end
        foreach (GIF_SIG[i])
            file_bytes.push_back(GIF_SIG[i]);
        file_bytes.push_back(CH_8);
        file_bytes.push_back(($urandom_range(0, 3) != 0) ? CH_9 : CH_7);
        file_bytes.push_back(CH_A);
        if ($urandom_range(0, 15) == 0)
            file_bytes[$urandom_range(0, 5)] = 8'($urandom);
        repeat (4) file_bytes.push_back(8'($urandom));
        flags      = 8'($urandom);
        flags[2:0] = pick_table_size();
        // One file carries the largest global color table, cut off inside the
        // table to keep the run short
        if (wide_table_due)
        begin
            flags[7]       = 1'b1;
            flags[2:0]     = 3'd7;
            wide_table_due = 1'b0;
            cut_short      = 1'b1;
        end
        file_bytes.push_back(flags);
        file_bytes.push_back(8'($urandom));
        roll = $urandom_range(0, 19);
        file_bytes.push_back((roll == 0) ? 8'($urandom) : ((roll < 10) ? 8'h00 : ASPECT_ALT));
        add_table(flags);
        repeat ($urandom_range(0, 4))
        begin
            roll = $urandom_range(0, 9);
            if (roll < 4)
                add_extension();
            else if (roll < 8)
                add_image();
            else
                file_bytes.push_back(8'($urandom));
        end
        file_bytes.push_back(CH_TERM);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
        // Now and then cut the file short at a random point
        keep = file_bytes.size();
        if (cut_short)
            keep = 13 + $urandom_range(16, 48);
        else if ($urandom_range(0, 7) == 0)
            keep = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > keep)
            void'(file_bytes.pop_back());
    endtask

    // ------------------------------------------------------------------
    // Input channel driver
    // ------------------------------------------------------------------
    // Offer one byte, hold it until the transaction completes, then predict.
    // A typed-in expectation replaces the predicted one for directed rows.
    task automatic send_byte(input logic [7:0] b, input logic l, input logic has_want,
                             input result_t want);
        bit      got;
        result_t r;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= l;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
        parse_gif_byte(b, l, got, r);
        if (has_want)
            awaited_reports.push_back(want);
        else if (got)
            awaited_reports.push_back(r);
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], (i == file_bytes.size() - 1), 1'b0, NO_WANT);
    endtask

    // Drop valid and wait for every outstanding report, with a bound.
    task automatic drain_results();
        int n;
        in_ch.valid <= 1'b0;
        n = 0;
        do
        begin
            @(posedge clk);
            n++;
        end while (awaited_reports.size() != 0 && n < DRAIN_LIMIT);
    endtask

    // ------------------------------------------------------------------
    // Output side: ready pattern and report checker
    // ------------------------------------------------------------------
    // Ready is decided once per edge. A long hold, counted here, is armed by
    // long_hold_req and runs once per arming so the scanner backs up.
    initial
    begin
        int hold_count;
        hold_count   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && hold_count < HOLD_CYCLES)
            begin
                out_ch.ready <= 1'b0;
                hold_count++;
            end
            else
            begin
                if (!long_hold_req)
                    hold_count = 0;
                out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned seen);
        if (want != seen)
        begin
            $error("%s: expected %0d, actual %0d", field, want, seen);
            mismatch_count++;
        end
    endtask

    // Every completed output transaction is matched against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (awaited_reports.size() == 0)
            begin
                $error("report with none expected: image_count %0d, status %0d",
                       out_ch.image_count, out_ch.status);
                mismatch_count++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                compare_field("image_count", want.image_count, out_ch.image_count);
                compare_field("status", want.status, out_ch.status);
                compare_field("loop_count", want.loop_count, out_ch.loop_count);
                compare_field("version_89a", want.version_89a, out_ch.version_89a);
                compare_field("loop_ext_found", want.loop_ext_found, out_ch.loop_ext_found);
                compare_field("graphic_control_first", want.graphic_control_first,
                              out_ch.graphic_control_first);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase_start;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        clear_scanner();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows: header and aspect errors, drop-after-report, truncation
        foreach (DIRECTED[i])
            send_byte(DIRECTED[i].data_byte, DIRECTED[i].last_byte,
                      DIRECTED[i].has_want, DIRECTED[i].want);
        drain_results();

        // Random files under each traffic pattern; the sender pauses after
        // each phase until every report has come back.
        for (int m = 0; m < 4; m++)
        begin
            tx_idle_pct  = TX_IDLE_PCT[m];
            rx_stall_pct = RX_STALL_PCT[m];
            phase_start  = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                build_file();
                send_file();
            end
            drain_results();
        end

        // Back-pressure: hold ready low while short files keep coming, so a
        // report sits in the output and the input channel stalls.
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        long_hold_req = 1'b1;
        repeat (24)
        begin
            file_bytes.delete();
            repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
            send_file();
        end
        drain_results();
        long_hold_req = 1'b0;

        // Let any stray late report surface before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_reports.size() != 0)
        begin
            $error("%0d expected reports never arrived", awaited_reports.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("status: fail");
        $finish;
    end

endmodule
